/* rtl/core/dmx_pkg.sv */
// Shared types and constants of the DMX512 frame receiver.
package dmx_pkg;

    localparam int unsigned IDX_W  = 10;
    localparam int unsigned LEN_W  = 10;
    localparam int unsigned CHAR_W = 9;
    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] NULL_START_CODE = 8'h00;
    localparam logic [BYTE_W-1:0] OVERFLOW_MARK   = 8'hFF;
    localparam logic [BYTE_W-1:0] RDM_CODE_RESET  = 8'hCC;
    localparam logic [CHAR_W-1:0] BREAK_CHAR      = 9'h000;

    localparam logic FUNC_CHAR    = 1'b0;
    localparam logic FUNC_TIMEOUT = 1'b1;

    typedef enum logic
    {
        ST_AWAIT_BREAK,
        ST_RECEIVING
    } state_t;

    typedef struct packed
    {
        logic              func;
        logic [CHAR_W-1:0] char_bits;
        logic              framing_error;
    } in_item_t;

    typedef struct packed
    {
        logic              slot_write;
        logic [IDX_W-1:0]  slot_index;
        logic [BYTE_W-1:0] slot_value;
        logic              line_activity;
        logic              frame_ready;
        logic              rdm_ready;
        logic [LEN_W-1:0]  length;
    } out_item_t;

    typedef struct packed
    {
        logic advance;
    } flow_t;

endpackage

/* rtl/core/dmx_if.sv */
// Valid/ready channel interfaces for receive events and results.
interface dmx_in_if;
    logic               valid;
    logic               ready;
    dmx_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dmx_out_if;
    logic               valid;
    logic               ready;
    dmx_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/dmx_in_stage.sv */
// Input register that holds one receive event until the core takes it.
module dmx_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    dmx_in_if.sink            rx,
    input  dmx_pkg::flow_t    flow,
    output logic              item_valid,
    output dmx_pkg::in_item_t item
);
    import dmx_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     take;

    assign rx.ready   = !valid_reg || flow.advance;
    assign take       = rx.valid && rx.ready;
    assign valid_next = take ? 1'b1 : (flow.advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= rx.data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
endmodule

/* rtl/core/dmx_frame_ctl.sv */
// Frame state, slot counting and result computation for one event.
module dmx_frame_ctl
#(
    parameter int unsigned BUFFER_SLOTS = 513
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [dmx_pkg::BYTE_W-1:0] cfg_wdata,
    input  dmx_pkg::flow_t             flow,
    input  dmx_pkg::in_item_t          item,
    output dmx_pkg::out_item_t         result
);
    import dmx_pkg::*;

    localparam int unsigned CNT_W = $clog2(BUFFER_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS = CNT_W'(BUFFER_SLOTS);

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  prev_len_reg;
    logic [CNT_W-1:0]  prev_len_next;
    logic [BYTE_W-1:0] prev_sc_reg;
    logic [BYTE_W-1:0] prev_sc_next;
    logic [BYTE_W-1:0] cur_sc_reg;
    logic [BYTE_W-1:0] cur_sc_next;
    logic [BYTE_W-1:0] rdm_sc_reg;

    logic slot_ok;
    logic is_break;
    logic has_room;
    logic is_rdm;
    logic has_slots;

    assign slot_ok   = (state_reg == ST_RECEIVING) && !item.framing_error
                       && item.char_bits[CHAR_W-1];
    assign is_break  = item.framing_error && (item.char_bits == BREAK_CHAR);
    assign has_room  = count_reg < SLOTS;
    assign is_rdm    = cur_sc_reg == rdm_sc_reg;
    assign has_slots = count_reg != '0;

    always_comb
    begin
        state_next = state_reg;
        case (item.func)
            FUNC_CHAR:
            begin
                if (slot_ok)
                begin
                    state_next = has_room ? ST_RECEIVING : ST_AWAIT_BREAK;
                end
                else if (is_break)
                begin
                    state_next = ST_RECEIVING;
                end
                else
                begin
                    state_next = ST_AWAIT_BREAK;
                end
            end
            FUNC_TIMEOUT:
            begin
                if (has_slots && !is_rdm)
                begin
                    state_next = ST_AWAIT_BREAK;
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    always_comb
    begin
        result        = '0;
        count_next    = count_reg;
        prev_len_next = prev_len_reg;
        prev_sc_next  = prev_sc_reg;
        cur_sc_next   = cur_sc_reg;
        case (item.func)
            FUNC_CHAR:
            begin
                if (slot_ok)
                begin
                    result.line_activity = 1'b1;
                    result.slot_write    = 1'b1;
                    if (has_room)
                    begin
                        result.slot_index = IDX_W'(count_reg);
                        result.slot_value = item.char_bits[BYTE_W-1:0];
                        if (!has_slots)
                        begin
                            cur_sc_next = item.char_bits[BYTE_W-1:0];
                        end
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        result.slot_value = OVERFLOW_MARK;
                        cur_sc_next       = OVERFLOW_MARK;
                    end
                end
                else if (is_break)
                begin
                    result.line_activity = 1'b1;
                    count_next           = '0;
                end
            end
            FUNC_TIMEOUT:
            begin
                if (has_slots)
                begin
                    if (is_rdm)
                    begin
                        result.rdm_ready = 1'b1;
                        result.length    = LEN_W'(count_reg);
                        prev_len_next    = '0;
                    end
                    else
                    begin
                        if ((prev_len_reg == count_reg) && (prev_sc_reg == NULL_START_CODE)
                            && (cur_sc_reg == NULL_START_CODE))
                        begin
                            result.frame_ready = 1'b1;
                            result.length      = LEN_W'(count_reg);
                        end
                        prev_len_next = count_reg;
                        prev_sc_next  = cur_sc_reg;
                        count_next    = '0;
                    end
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_AWAIT_BREAK;
            count_reg    <= '0;
            prev_len_reg <= '0;
            prev_sc_reg  <= NULL_START_CODE;
            cur_sc_reg   <= NULL_START_CODE;
            rdm_sc_reg   <= RDM_CODE_RESET;
        end
        else
        begin
            if (flow.advance)
            begin
                state_reg    <= state_next;
                count_reg    <= count_next;
                prev_len_reg <= prev_len_next;
                prev_sc_reg  <= prev_sc_next;
                cur_sc_reg   <= cur_sc_next;
            end
            if (cfg_we)
            begin
                rdm_sc_reg <= cfg_wdata;
            end
        end
    end
endmodule

/* rtl/core/dmx_out_stage.sv */
// Result register that presents one result item until it is taken.
module dmx_out_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  dmx_pkg::flow_t     flow,
    input  dmx_pkg::out_item_t result,
    output logic               can_load,
    dmx_out_if.source          tx
);
    import dmx_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    assign can_load   = !valid_reg || tx.ready;
    assign valid_next = flow.advance ? 1'b1 : (tx.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flow.advance)
        begin
            data_reg <= result;
        end
    end

    assign tx.valid = valid_reg;
    assign tx.data  = data_reg;
endmodule

/* rtl/core/dmx512_frame_receiver.sv */
// Top level of the DMX512 / RDM frame receiver.
// Each receive event (a character with its framing-error flag, or a receiver timeout) yields
// exactly one result item, and a new event can be accepted in every cycle: the event passes
// through an input register, the frame logic, and a result register, so throughput is one
// item per clock and is reduced only by back-pressure on the result channel. The RDM start
// code register may be written only while no event is in flight.
module dmx512_frame_receiver
#(
    parameter int unsigned BUFFER_SLOTS = 513
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [dmx_pkg::BYTE_W-1:0] cfg_wdata,
    dmx_in_if.sink                     rx,
    dmx_out_if.source                  tx
);
    import dmx_pkg::*;

    flow_t     flow;
    logic      item_valid;
    in_item_t  item;
    out_item_t result;
    logic      can_load;

    assign flow.advance  = item_valid && can_load;

    dmx_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .flow       (flow),
        .item_valid (item_valid),
        .item       (item)
    );

    dmx_frame_ctl #(.BUFFER_SLOTS(BUFFER_SLOTS)) u_ctl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .flow      (flow),
        .item      (item),
        .result    (result)
    );

    dmx_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .flow     (flow),
        .result   (result),
        .can_load (can_load),
        .tx       (tx)
    );
endmodule

/* rtl/core/dmx_checker.sv */
// Port-level checks of the DMX512 frame receiver and their binding.
module dmx_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input dmx_pkg::out_item_t out_data
);
    import dmx_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("Result item withdrawn before it was taken.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.frame_ready && out_data.rdm_ready))
    else $error("Frame and RDM packet reported together.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.frame_ready && !out_data.rdm_ready |-> out_data.length == '0)
    else $error("Length given without a completed frame.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.slot_write |-> out_data.line_activity
            && !out_data.frame_ready && !out_data.rdm_ready)
    else $error("Slot write without line activity or alongside a report.");
endmodule

bind dmx512_frame_receiver dmx_checker u_dmx_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (tx.valid),
    .out_ready (tx.ready),
    .out_data  (tx.data)
);

/* test/dmx_frame_checker.sv */
`timescale 1ns / 1ps
// Checker for the DMX512 frame receiver: predicts each result item from accepted events and compares.
module dmx_frame_checker
#(
    parameter int unsigned BUFFER_SLOTS = 513
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [dmx_pkg::BYTE_W-1:0] cfg_wdata,
    input  logic                       ev_valid,
    input  logic                       ev_ready,
    input  dmx_pkg::in_item_t          ev_item,
    input  logic                       res_valid,
    input  logic                       res_ready,
    input  dmx_pkg::out_item_t         res_item,
    output int                         failures,
    output int                         outstanding
);

    import dmx_pkg::*;

    state_t            rx_state;
    int unsigned       slot_cnt;
    int unsigned       prev_len;
    logic [BYTE_W-1:0] prev_code;
    logic [BYTE_W-1:0] cur_code;
    logic [BYTE_W-1:0] rdm_code;
    out_item_t         expected_slots[$];
    out_item_t         want;
    int                fail_seen;
    int                result_no;

    function automatic out_item_t predict_result(in_item_t ev);
        out_item_t r;
        r = '0;
        if (ev.func == FUNC_TIMEOUT)
        begin
            if (slot_cnt != 0)
            begin
                if (cur_code == rdm_code)
                begin
                    r.rdm_ready = 1'b1;
                    r.length    = LEN_W'(slot_cnt);
                    prev_len    = 0;
                end
                else
                begin
                    if (prev_len == slot_cnt && prev_code == NULL_START_CODE
                        && cur_code == NULL_START_CODE)
                    begin
                        r.frame_ready = 1'b1;
                        r.length      = LEN_W'(slot_cnt);
                    end
                    prev_len  = slot_cnt;
                    prev_code = cur_code;
                    slot_cnt  = 0;
                    rx_state  = ST_AWAIT_BREAK;
                end
            end
        end
        else
        begin
            if (ev.framing_error || !ev.char_bits[CHAR_W-1])
                rx_state = ST_AWAIT_BREAK;
            if (rx_state == ST_RECEIVING)
            begin
                r.line_activity = 1'b1;
                r.slot_write    = 1'b1;
                if (slot_cnt < BUFFER_SLOTS)
                begin
                    r.slot_index = IDX_W'(slot_cnt);
                    r.slot_value = ev.char_bits[BYTE_W-1:0];
                    if (slot_cnt == 0)
                        cur_code = r.slot_value;
                    slot_cnt++;
                end
                else
                begin
                    rx_state     = ST_AWAIT_BREAK;
                    r.slot_index = '0;
                    r.slot_value = OVERFLOW_MARK;
                    cur_code     = OVERFLOW_MARK;
                end
            end
            else if (ev.framing_error && ev.char_bits == BREAK_CHAR)
            begin
                r.line_activity = 1'b1;
                rx_state        = ST_RECEIVING;
                slot_cnt        = 0;
            end
        end
        return r;
    endfunction

    function automatic string result_text(out_item_t r);
        return $sformatf("wr=%0b idx=%0d val=%02h act=%0b frame=%0b rdm=%0b len=%0d",
                         r.slot_write, r.slot_index, r.slot_value, r.line_activity,
                         r.frame_ready, r.rdm_ready, r.length);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_state  = ST_AWAIT_BREAK;
            slot_cnt  = 0;
            prev_len  = 0;
            prev_code = NULL_START_CODE;
            cur_code  = NULL_START_CODE;
            rdm_code  = RDM_CODE_RESET;
            fail_seen = 0;
            result_no = 0;
            expected_slots.delete();
            failures    <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                rdm_code = cfg_wdata;
            if (res_valid && res_ready)
            begin
                if (expected_slots.size() == 0)
                begin
                    if (fail_seen < 10)
                        $display("result %0d arrived with none expected: %s",
                                 result_no, result_text(res_item));
                    fail_seen++;
                end
                else
                begin
                    want = expected_slots.pop_front();
                    if (res_item !== want)
                    begin
                        if (fail_seen < 10)
                            $display("result %0d mismatch: expected %s, got %s",
                                     result_no, result_text(want), result_text(res_item));
                        fail_seen++;
                    end
                end
                result_no++;
            end
            if (ev_valid && ev_ready)
                expected_slots.push_back(predict_result(ev_item));
            failures    <= fail_seen;
            outstanding <= expected_slots.size();
        end
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for the DMX512 frame receiver: clock, reset, receive-event stimulus and verdict.
module tb_top;

    import dmx_pkg::*;

    localparam int unsigned SLOTS       = 513;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned LONG_HOLD   = 300;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [BYTE_W-1:0] cfg_wdata;

    dmx_in_if  rx();
    dmx_out_if tx();

    int          failures;
    int          outstanding;
    int unsigned cycles;
    int unsigned items_sent;
    int unsigned send_gap_pct;
    int unsigned stall_pct;
    int unsigned hold_requests;
    int unsigned hold_served;
    int unsigned hold_left;
    int unsigned last_len;
    logic        offering;
    logic [7:0]  rdm_code_now;

    dmx512_frame_receiver #(.BUFFER_SLOTS(SLOTS)) DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rx        (rx),
        .tx        (tx)
    );

    dmx_frame_checker #(.BUFFER_SLOTS(SLOTS)) result_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .ev_valid    (rx.valid),
        .ev_ready    (rx.ready),
        .ev_item     (rx.data),
        .res_valid   (tx.valid),
        .res_ready   (tx.ready),
        .res_item    (tx.data),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("dmx512_frame_receiver test failed");
            $finish;
        end
    end

    // The result side stalls at random, or holds off for a long stretch when asked.
    always @(posedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            tx.ready <= 1'b0;
        end
        else
            tx.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_event(input logic func, input logic [CHAR_W-1:0] bits,
                              input logic ferr);
        in_item_t ev;
        ev.func          = func;
        ev.char_bits     = bits;
        ev.framing_error = ferr;
        rx.data <= ev;
        if (!offering)
        begin
            rx.valid <= 1'b1;
            offering = 1'b1;
        end
        @(posedge clk);
        while (!rx.ready)
            @(posedge clk);
        items_sent++;
        while ($urandom_range(99) < send_gap_pct)
        begin
            if (offering)
            begin
                rx.valid <= 1'b0;
                offering = 1'b0;
            end
            @(posedge clk);
        end
    endtask

    task automatic send_break();
        send_event(FUNC_CHAR, BREAK_CHAR, 1'b1);
    endtask

    task automatic send_slot(input logic [7:0] value);
        send_event(FUNC_CHAR, {1'b1, value}, 1'b0);
    endtask

    task automatic send_timeout();
        send_event(FUNC_TIMEOUT, 9'($urandom_range(511)), 1'($urandom_range(1)));
    endtask

    task automatic wait_idle();
        if (offering)
        begin
            rx.valid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_rdm_code(input logic [7:0] code);
        cfg_wdata <= code;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        rdm_code_now = code;
        @(posedge clk);
    endtask

    // Mostly well-formed frames with random content; the rest is noise or aborted frames.
    task automatic send_random_frame();
        int unsigned kind;
        int unsigned n;
        logic [7:0]  code;
        kind = $urandom_range(99);
        if (kind < 12)
        begin
            repeat ($urandom_range(1, 4))
                send_event(1'($urandom_range(1)), 9'($urandom_range(511)),
                           1'($urandom_range(1)));
        end
        else
        begin
            send_break();
            case ($urandom_range(3))
                0, 1:    code = NULL_START_CODE;
                2:       code = rdm_code_now;
                default: code = 8'($urandom_range(255));
            endcase
            if ($urandom_range(1) == 0 && last_len != 0)
                n = last_len;
            else
                n = $urandom_range(1, 6);
            last_len = n;
            send_slot(code);
            for (int i = 1; i < n; i++)
                send_slot(8'($urandom_range(255)));
            if (kind < 25)
            begin
                send_event(FUNC_CHAR, {1'($urandom_range(1)), 8'($urandom_range(255))},
                           1'b1);
                send_event(FUNC_CHAR, {1'b0, 8'($urandom_range(255))}, 1'b0);
                send_slot(8'($urandom_range(255)));
            end
            send_timeout();
            if ($urandom_range(3) == 0)
                send_timeout();
        end
    endtask

    task automatic run_phase(input int unsigned gap, input int unsigned stall,
                             input int unsigned quota);
        send_gap_pct = gap;
        stall_pct    = stall;
        while (items_sent < quota)
            send_random_frame();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        rx.valid      = 1'b0;
        rx.data       = '0;
        tx.ready      = 1'b0;
        offering      = 1'b0;
        cycles        = 0;
        items_sent    = 0;
        send_gap_pct  = 0;
        stall_pct     = 0;
        hold_requests = 0;
        hold_served   = 0;
        hold_left     = 0;
        last_len      = 0;
        rdm_code_now  = RDM_CODE_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_timeout();
        send_event(FUNC_CHAR, 9'h155, 1'b0);
        send_event(FUNC_CHAR, 9'h0FF, 1'b1);
        send_break();
        send_slot(NULL_START_CODE);
        send_slot(8'hFF);
        send_slot(8'h80);
        send_timeout();
        send_break();
        send_slot(NULL_START_CODE);
        send_slot(8'hFF);
        send_slot(8'h01);
        send_timeout();
        send_break();
        send_slot(RDM_CODE_RESET);
        send_slot(8'h7F);
        send_timeout();
        send_timeout();
        send_event(FUNC_CHAR, 9'h0AA, 1'b0);
        send_slot(8'h55);
        send_break();
        send_slot(8'h12);
        send_event(FUNC_CHAR, 9'h1FF, 1'b1);
        send_timeout();
        send_break();
        wait_idle();

        // The result side holds off while the sender keeps offering, so the input stalls.
        hold_requests++;
        run_phase(0, 0, 230);
        wait_idle();

        write_rdm_code(8'h00);
        run_phase(57, 0, 400);
        wait_idle();

        write_rdm_code(8'hFF);
        send_gap_pct = 0;
        stall_pct    = 57;
        send_break();
        for (int i = 0; i <= SLOTS; i++)
            send_slot(i == 0 ? NULL_START_CODE : 8'($urandom_range(255)));
        send_slot(8'h42);
        send_timeout();
        send_timeout();
        run_phase(0, 57, 1000);
        wait_idle();

        write_rdm_code(8'($urandom_range(1, 254)));
        run_phase(14, 14, 1090);
        wait_idle();

        write_rdm_code(RDM_CODE_RESET);
        run_phase(0, 0, 1150);
        wait_idle();

        if (failures == 0 && outstanding == 0)
            $display("dmx512_frame_receiver test passed");
        else
            $display("dmx512_frame_receiver test failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/dmx_pkg.sv
rtl/core/dmx_if.sv
rtl/core/dmx_in_stage.sv
rtl/core/dmx_frame_ctl.sv
rtl/core/dmx_out_stage.sv
rtl/core/dmx512_frame_receiver.sv
rtl/core/dmx_checker.sv
test/dmx_frame_checker.sv
test/tb_top.sv
